[rtl/core/tilt_angle_from_accel_defines.svh]
// assertion macros for the tilt angle block
`ifndef TILT_ANGLE_FROM_ACCEL_DEFINES_SVH
`define TILT_ANGLE_FROM_ACCEL_DEFINES_SVH

// checked only while out of reset
`define TAFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TAFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tafa_pkg.sv]
package tafa_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int PRESCALE_BITS     = 24;
  localparam int HEADROOM_BITS     = 4;
  localparam int ANGLE_FRAC        = 16;
  localparam int ANGLE_W           = 26;
  localparam int ROT_W             = 12;
  localparam int OUT_TDATA_W       = 16;
  localparam int TENTHS_W          = ANGLE_W + 4 - ANGLE_FRAC;

  localparam int DEG_HALF_TURN     = 180;
  localparam int DEG_FULL_TURN     = 360;
  localparam int TENTHS_PER_DEG    = 10;

  localparam logic signed [ANGLE_W-1:0] HALF_TURN =
    ANGLE_W'(DEG_HALF_TURN * (1 << ANGLE_FRAC));
  localparam logic signed [ANGLE_W-1:0] FULL_TURN =
    ANGLE_W'(DEG_FULL_TURN * (1 << ANGLE_FRAC));
  localparam logic [TENTHS_W-1:0] TENTHS_STRAIGHT =
    TENTHS_W'(DEG_HALF_TURN * TENTHS_PER_DEG);
  localparam logic [TENTHS_W-1:0] TENTHS_MAX =
    TENTHS_W'(DEG_FULL_TURN * TENTHS_PER_DEG - 1);

  // atan(2^-i) in degrees, 16 fractional bits
  localparam logic signed [ANGLE_W-1:0] ATAN_LUT [MAX_STAGES] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234378,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic u_zero;
    logic u_pos;
    logic v_neg;
  } tafa_flags_t;

endpackage

[rtl/core/tilt_angle_from_accel.sv]
// path: tafa_prep register, the cordic cell registers, tafa_post register, out_tdata
// throughput: one request per cycle while out_tready does not stall the chain
// each stage holds its request while the next one is full, so a stalled output
// only backs up as far as the first free stage
// reset: rst_n low empties every stage; no memory to clear, ready right after reset
module tilt_angle_from_accel import tafa_pkg::*; #(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int IN_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // accel_x, accel_y, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata  // rotation_tenths, zero pad
);

  localparam int DW = SAMPLE_WIDTH + PRESCALE_BITS + HEADROOM_BITS;

  logic                      vld   [CORDIC_STAGES+1];
  logic                      rdy   [CORDIC_STAGES+1];
  logic signed [DW-1:0]      cx    [CORDIC_STAGES+1];
  logic signed [DW-1:0]      cy    [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] z     [CORDIC_STAGES+1];
  tafa_flags_t               flags [CORDIC_STAGES+1];
  logic [ROT_W-1:0]          rotation_tenths;

  tafa_prep #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DW          (DW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .accel_x  ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .accel_y  ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .out_valid(vld[0]),
    .out_ready(rdy[0]),
    .out_cx   (cx[0]),
    .out_cy   (cy[0]),
    .out_z    (z[0]),
    .out_flags(flags[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    tafa_cell #(
      .DW   (DW),
      .STAGE(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[k]),
      .in_ready (rdy[k]),
      .in_cx    (cx[k]),
      .in_cy    (cy[k]),
      .in_z     (z[k]),
      .in_flags (flags[k]),
      .out_valid(vld[k+1]),
      .out_ready(rdy[k+1]),
      .out_cx   (cx[k+1]),
      .out_cy   (cy[k+1]),
      .out_z    (z[k+1]),
      .out_flags(flags[k+1])
    );
  end

  tafa_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (vld[CORDIC_STAGES]),
    .in_ready       (rdy[CORDIC_STAGES]),
    .in_z           (z[CORDIC_STAGES]),
    .in_flags       (flags[CORDIC_STAGES]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .rotation_tenths(rotation_tenths)
  );

  assign out_tdata = {{(OUT_TDATA_W - ROT_W){1'b0}}, rotation_tenths};

endmodule

[rtl/core/tafa_prep.sv]
module tafa_prep import tafa_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int DW           = SAMPLE_WIDTH_DEF + PRESCALE_BITS + HEADROOM_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DW-1:0]        out_cx,
  output logic signed [DW-1:0]        out_cy,
  output logic signed [ANGLE_W-1:0]   out_z,
  output tafa_flags_t                 out_flags
);

  logic                      valid_r, valid_nxt;
  logic signed [DW-1:0]      cx_r, cx_nxt;
  logic signed [DW-1:0]      cy_r, cy_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  tafa_flags_t               flags_r, flags_nxt;
  logic signed [SAMPLE_WIDTH:0] u_s;
  logic signed [DW-1:0]      cx0;
  logic signed [DW-1:0]      cy0;

  assign in_ready = !valid_r || out_ready;
  assign u_s = -$signed({accel_x[SAMPLE_WIDTH-1], accel_x});
  assign cx0 = {{(DW - SAMPLE_WIDTH - PRESCALE_BITS){accel_y[SAMPLE_WIDTH-1]}},
                accel_y, {PRESCALE_BITS{1'b0}}};
  assign cy0 = {{(DW - SAMPLE_WIDTH - 1 - PRESCALE_BITS){u_s[SAMPLE_WIDTH]}},
                u_s, {PRESCALE_BITS{1'b0}}};

  always_comb begin
    valid_nxt        = in_ready ? in_valid : valid_r;
    flags_nxt.u_zero = (accel_x == '0);
    flags_nxt.u_pos  = accel_x[SAMPLE_WIDTH-1];
    flags_nxt.v_neg  = accel_y[SAMPLE_WIDTH-1];
    // left half plane: turn by a half circle first
    if (flags_nxt.v_neg) begin
      cx_nxt = -cx0;
      cy_nxt = -cy0;
      z_nxt  = u_s[SAMPLE_WIDTH] ? -HALF_TURN : HALF_TURN;
    end else begin
      cx_nxt = cx0;
      cy_nxt = cy0;
      z_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      z_r     <= z_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cx    = cx_r;
  assign out_cy    = cy_r;
  assign out_z     = z_r;
  assign out_flags = flags_r;

endmodule

[rtl/core/tafa_cell.sv]
module tafa_cell import tafa_pkg::*; #(
  parameter int DW    = SAMPLE_WIDTH_DEF + PRESCALE_BITS + HEADROOM_BITS,
  parameter int STAGE = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DW-1:0]      in_cx,
  input  logic signed [DW-1:0]      in_cy,
  input  logic signed [ANGLE_W-1:0] in_z,
  input  tafa_flags_t               in_flags,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DW-1:0]      out_cx,
  output logic signed [DW-1:0]      out_cy,
  output logic signed [ANGLE_W-1:0] out_z,
  output tafa_flags_t               out_flags
);

  logic                      valid_r, valid_nxt;
  logic signed [DW-1:0]      cx_r, cx_nxt;
  logic signed [DW-1:0]      cy_r, cy_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  tafa_flags_t               flags_r;
  logic signed [DW-1:0]      dx;
  logic signed [DW-1:0]      dy;

  assign in_ready = !valid_r || out_ready;
  assign dx = in_cy >>> STAGE;
  assign dy = in_cx >>> STAGE;

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
    // rotate toward the x axis
    if (!in_cy[DW-1]) begin
      cx_nxt = in_cx + dx;
      cy_nxt = in_cy - dy;
      z_nxt  = in_z + ATAN_LUT[STAGE];
    end else begin
      cx_nxt = in_cx - dx;
      cy_nxt = in_cy + dy;
      z_nxt  = in_z - ATAN_LUT[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      z_r     <= z_nxt;
      flags_r <= in_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_cx    = cx_r;
  assign out_cy    = cy_r;
  assign out_z     = z_r;
  assign out_flags = flags_r;

endmodule

[rtl/core/tafa_post.sv]
module tafa_post import tafa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_z,
  input  tafa_flags_t               in_flags,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ROT_W-1:0]          rotation_tenths
);

  logic                      valid_r, valid_nxt;
  logic [ROT_W-1:0]          rot_r, rot_nxt;
  logic signed [ANGLE_W-1:0] z_wrap;
  logic [ANGLE_W+3:0]        scaled;
  logic [TENTHS_W-1:0]       tenths;
  logic [TENTHS_W-1:0]       clamped;

  assign in_ready = !valid_r || out_ready;
  assign z_wrap   = in_z[ANGLE_W-1] ? in_z + FULL_TURN : in_z;
  assign scaled   = {4'b0, z_wrap} * (ANGLE_W + 4)'(TENTHS_PER_DEG);
  assign tenths   = scaled[ANGLE_W+3:ANGLE_FRAC];

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
    // keep the result on the half circle that the sign of u selects
    if (in_flags.u_pos) begin
      clamped = (tenths > TENTHS_STRAIGHT) ? TENTHS_STRAIGHT : tenths;
    end else if (tenths < TENTHS_STRAIGHT) begin
      clamped = TENTHS_STRAIGHT;
    end else if (tenths > TENTHS_MAX) begin
      clamped = TENTHS_MAX;
    end else begin
      clamped = tenths;
    end
    if (in_flags.u_zero) begin
      rot_nxt = in_flags.v_neg ? TENTHS_STRAIGHT[ROT_W-1:0] : '0;
    end else begin
      rot_nxt = clamped[ROT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign rotation_tenths = rot_r;

endmodule

[rtl/core/tafa_checker.sv]
`include "tilt_angle_from_accel_defines.svh"

module tafa_checker import tafa_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [ROT_W-1:0] rot;
  logic             rot_ok;
  logic             in_seen;
  logic             out_stall;

  assign rot       = out_tdata[ROT_W-1:0];
  assign rot_ok    = (rot <= TENTHS_MAX[ROT_W-1:0]) && (out_tdata[OUT_TDATA_W-1:ROT_W] == '0);
  assign in_seen   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  `TAFA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result right after reset")
  `TAFA_ASSERT(a_range, clk, rst_n, out_tvalid |-> rot_ok, "result out of range")
  `TAFA_ASSERT(a_no_early, clk, rst_n, ($past(!rst_n) && !in_seen) |=> !out_tvalid, "early result")
  `TAFA_ASSERT(a_hold, clk, rst_n, out_stall |=> (out_tvalid && $stable(out_tdata)), "result changed")

endmodule

bind tilt_angle_from_accel tafa_checker u_tafa_checker (.*);
